FILE: src/hsc_pkg.sv
package hsc_pkg;

    // Widest data word the codec supports; the code word field is sized for it.
    localparam int MAX_DATA_BITS = 32;
    localparam int DW_W          = 32;
    localparam int CW_W          = 38;
    localparam int SYN_W         = 6;
    localparam int CFG_W         = 6;
    localparam int STATUS_W      = 2;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Width and code word length in use right after reset (four data bits).
    localparam logic [CFG_W-1:0] RESET_DATA_BITS = CFG_W'(4);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_CORRECTED = 2'd1,
        STATUS_BEYOND    = 2'd2
    } t_status;

    function automatic logic is_pow2(input int pos);
        return (pos & (pos - 1)) == 0;
    endfunction

    // Index of the data bit held at a position that is not a power of two.
    function automatic int data_index(input int pos);
        int k;
        k = 0;
        for (int i = 1; i < pos; i++) begin
            if (!is_pow2(i)) begin
                k++;
            end
        end
        return k;
    endfunction

    // A width of zero acts as one bit, anything above the maximum as the maximum.
    function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] m;
        m = v;
        if (m == '0) begin
            m = CFG_W'(1);
        end else if (int'(m) > MAX_DATA_BITS) begin
            m = CFG_W'(MAX_DATA_BITS);
        end
        return m;
    endfunction

    // Code word length n = m + r, with r the smallest count where 2^r >= m + r + 1.
    function automatic logic [CFG_W-1:0] code_len(input logic [CFG_W-1:0] m);
        int r;
        r = 0;
        for (int j = 0; j < 7; j++) begin
            if ((1 << r) < int'(m) + r + 1) begin
                r++;
            end
        end
        return CFG_W'(int'(m) + r);
    endfunction

    // XOR of the position numbers of all bits that are set.
    function automatic logic [SYN_W-1:0] syndrome(input logic [CW_W-1:0] cw);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int i = 1; i <= CW_W; i++) begin
            if (cw[i-1]) begin
                s = s ^ SYN_W'(i);
            end
        end
        return s;
    endfunction

    function automatic logic [DW_W-1:0] gather_data(input logic [CW_W-1:0] cw);
        logic [DW_W-1:0] d;
        int              k;
        d = '0;
        for (int i = 1; i <= CW_W; i++) begin
            k = data_index(i);
            if (!is_pow2(i) && k < DW_W) begin
                d[k] = cw[i-1];
            end
        end
        return d;
    endfunction

    function automatic logic [CW_W-1:0] scatter_data(input logic [DW_W-1:0] d);
        logic [CW_W-1:0] cw;
        int              k;
        cw = '0;
        for (int i = 1; i <= CW_W; i++) begin
            k = data_index(i);
            if (!is_pow2(i) && k < DW_W) begin
                cw[i-1] = d[k];
            end
        end
        return cw;
    endfunction

endpackage

FILE: src/hamming_sec_codec_top.sv
// An accepted input beat passes the input register, then the result register, and its
// result beat stays in the result register for as long as the sink holds it.
// Throughput: one code word per cycle while the sink stays ready; both stages hand
// over on the same edge. Reset (synchronous, active low) empties both stages and sets
// the data width to four bits, which gives a seven-bit code word.
module hamming_sec_codec_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hsc_pkg::CFG_W-1:0]     i_cfg_data_bits,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [hsc_pkg::DW_W-1:0]      i_data_word,
    input  logic [hsc_pkg::CW_W-1:0]      i_code_word,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hsc_pkg::CW_W-1:0]      o_code_word_out,
    output logic [hsc_pkg::DW_W-1:0]      o_data_out,
    output logic [hsc_pkg::SYN_W-1:0]     o_error_position,
    output logic [hsc_pkg::STATUS_W-1:0]  o_status
);
    import hsc_pkg::*;

    // Configuration. The width is clamped and the code word length derived when the
    // register is written, so the data path only sees two ready-made values.
    logic [CFG_W-1:0] r_data_bits;
    logic [CFG_W-1:0] r_cw_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_bits <= RESET_DATA_BITS;
            r_cw_len    <= code_len(RESET_DATA_BITS);
        end else if (i_cfg_valid) begin
            r_data_bits <= clamp_width(i_cfg_data_bits);
            r_cw_len    <= code_len(clamp_width(i_cfg_data_bits));
        end
    end

    // Two-stage pipeline. Each stage takes a new beat when it is empty or when its
    // current beat moves on in the same cycle, so a stalled sink backs up one stage
    // at a time and no beat is dropped.
    logic             r_in_valid;
    logic             r_in_mode;
    logic [DW_W-1:0]  r_in_data;
    logic [CW_W-1:0]  r_in_code;

    logic             r_out_valid;
    logic             r_out_mode;
    logic [CW_W-1:0]  r_out_code;
    logic [DW_W-1:0]  r_out_data;
    logic [SYN_W-1:0] r_out_syn;
    t_status          r_out_status;

    logic out_take;
    logic in_take;

    assign out_take   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || out_take;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode <= i_mode;
            r_in_data <= i_data_word;
            r_in_code <= i_code_word;
        end
    end

    // Encode and decode work side by side on the registered beat; the mode picks one.
    logic [DW_W-1:0]  data_mask;
    logic [CW_W-1:0]  len_mask;
    logic [DW_W-1:0]  enc_data;
    logic [CW_W-1:0]  enc_body;
    logic [SYN_W-1:0] enc_syn;
    logic [CW_W-1:0]  enc_cw;
    logic [CW_W-1:0]  dec_in;
    logic [SYN_W-1:0] dec_syn;
    logic [CW_W-1:0]  dec_flip;
    logic             dec_in_range;
    logic [CW_W-1:0]  dec_cw;
    t_status          dec_status;

    logic [CW_W-1:0]  n_out_code;
    logic [DW_W-1:0]  n_out_data;
    logic [SYN_W-1:0] n_out_syn;
    t_status          n_out_status;

    always_comb begin
        for (int k = 0; k < DW_W; k++) begin
            data_mask[k] = k < int'(r_data_bits);
        end
        for (int i = 1; i <= CW_W; i++) begin
            len_mask[i-1] = i <= int'(r_cw_len);
        end

        // Encoding: data bits go to the fixed non-power-of-two positions. Their
        // syndrome, written into the power-of-two positions, makes the total zero.
        enc_data = r_in_data & data_mask;
        enc_body = scatter_data(enc_data);
        enc_syn  = syndrome(enc_body);
        enc_cw   = enc_body;
        for (int t = 0; t < SYN_W; t++) begin
            if ((1 << t) <= CW_W) begin
                enc_cw[(1 << t) - 1] = enc_syn[t];
            end
        end

        // Decoding: a nonzero syndrome names the flipped position. One that points
        // past the code word length cannot be corrected and leaves the word as is.
        dec_in  = r_in_code & len_mask;
        dec_syn = syndrome(dec_in);
        for (int i = 1; i <= CW_W; i++) begin
            dec_flip[i-1] = dec_syn == SYN_W'(i);
        end
        dec_in_range = int'(dec_syn) <= int'(r_cw_len);
        if (dec_syn == '0) begin
            dec_cw     = dec_in;
            dec_status = STATUS_OK;
        end else if (dec_in_range) begin
            dec_cw     = dec_in ^ dec_flip;
            dec_status = STATUS_CORRECTED;
        end else begin
            dec_cw     = dec_in;
            dec_status = STATUS_BEYOND;
        end

        if (r_in_mode == MODE_DECODE) begin
            n_out_code   = dec_cw;
            n_out_data   = gather_data(dec_cw);
            n_out_syn    = dec_syn;
            n_out_status = dec_status;
        end else begin
            n_out_code   = enc_cw;
            n_out_data   = enc_data;
            n_out_syn    = '0;
            n_out_status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && out_take) begin
            r_out_mode   <= r_in_mode;
            r_out_code   <= n_out_code;
            r_out_data   <= n_out_data;
            r_out_syn    <= n_out_syn;
            r_out_status <= n_out_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_code_word_out  = r_out_code;
    assign o_data_out       = r_out_data;
    assign o_error_position = r_out_syn;
    assign o_status         = r_out_status;

`ifndef SYNTH
    // An encoded word never reports an error.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_out_mode == MODE_ENCODE) |->
            (o_status == STATUS_OK && o_error_position == '0))
        else $error("encode result carries an error report");

    // The status is clean exactly when the syndrome is zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == STATUS_OK) == (o_error_position == '0)))
        else $error("status and syndrome disagree");

    // A corrected position lies inside the code word, an uncorrectable one beyond it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STATUS_OK) |->
            ((o_status == STATUS_CORRECTED) == (o_error_position <= r_cw_len)))
        else $error("syndrome range does not match status");

    // No bit above the code word length leaves the block.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_code_word_out & ~len_mask) == '0))
        else $error("code word has bits beyond its length");
`endif

endmodule

FILE: tb/hamming_codec_checker.sv
module hamming_codec_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [hsc_pkg::CFG_W-1:0]     i_cfg_data_bits,

    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_mode,
    input  logic [hsc_pkg::DW_W-1:0]      i_data_word,
    input  logic [hsc_pkg::CW_W-1:0]      i_code_word,

    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [hsc_pkg::CW_W-1:0]      i_code_word_out,
    input  logic [hsc_pkg::DW_W-1:0]      i_data_out,
    input  logic [hsc_pkg::SYN_W-1:0]     i_error_position,
    input  logic [hsc_pkg::STATUS_W-1:0]  i_status,

    output int                            o_fail_count,
    output int                            o_pending
);

    import hsc_pkg::*;

    typedef struct packed {
        logic [CW_W-1:0]  code_word;
        logic [DW_W-1:0]  data;
        logic [SYN_W-1:0] error_position;
        t_status          status;
    } t_hamming_result;

    t_hamming_result  expected_q [$];
    t_hamming_result  want;
    logic [CFG_W-1:0] width_reg;
    int               fail_count = 0;

    // Encodes or corrects one word at the given width setting.
    function automatic t_hamming_result hamming_outcome(input logic mode,
                                                        input logic [DW_W-1:0] data_word,
                                                        input logic [CW_W-1:0] code_word,
                                                        input logic [CFG_W-1:0] width);
        t_hamming_result res;
        logic [63:0]     word;
        logic [63:0]     data;
        int              m;
        int              r;
        int              n;
        int              k;
        int              syn;
        int              i;
        int              t;
        m = int'(width);
        if (m < 1) begin
            m = 1;
        end
        if (m > MAX_DATA_BITS) begin
            m = MAX_DATA_BITS;
        end
        r = 0;
        while (r < 7 && (1 << r) < m + r + 1) begin
            r++;
        end
        n    = m + r;
        word = '0;
        data = '0;
        syn  = 0;
        k    = 0;
        res.status = STATUS_OK;
        if (mode == MODE_ENCODE) begin
            data = 64'(data_word) & ((64'd1 << m) - 64'd1);
            for (i = 1; i <= n; i++) begin
                if ((i & (i - 1)) != 0) begin
                    word[i-1] = data[k];
                    k++;
                end
            end
            for (i = 1; i <= n; i++) begin
                if (word[i-1]) begin
                    syn = syn ^ i;
                end
            end
            for (t = 0; t < r; t++) begin
                if (syn[t]) begin
                    word[(1 << t) - 1] = 1'b1;
                end
            end
            syn = 0;
        end else begin
            word = 64'(code_word) & ((64'd1 << n) - 64'd1);
            for (i = 1; i <= n; i++) begin
                if (word[i-1]) begin
                    syn = syn ^ i;
                end
            end
            if (syn != 0 && syn <= n) begin
                word[syn-1] = ~word[syn-1];
                res.status  = STATUS_CORRECTED;
            end else if (syn != 0) begin
                res.status = STATUS_BEYOND;
            end
            for (i = 1; i <= n; i++) begin
                if ((i & (i - 1)) != 0) begin
                    data[k] = word[i-1];
                    k++;
                end
            end
        end
        res.code_word      = word[CW_W-1:0];
        res.data           = data[DW_W-1:0];
        res.error_position = SYN_W'(syn);
        return res;
    endfunction

    task automatic flag_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg = RESET_DATA_BITS;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                width_reg = i_cfg_data_bits;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, i_code_word_out);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    flag_field("code word", 64'(want.code_word), 64'(i_code_word_out));
                    flag_field("data", 64'(want.data), 64'(i_data_out));
                    flag_field("error position", 64'(want.error_position),
                               64'(i_error_position));
                    flag_field("status", 64'(want.status), 64'(i_status));
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_q.insert(expected_q.size(),
                                  hamming_outcome(i_mode, i_data_word, i_code_word,
                                                  width_reg));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_q.size();
    end

endmodule

FILE: tb/hamming_sec_codec_top_tb.sv
module hamming_sec_codec_top_tb;

    import hsc_pkg::*;

    // Clock, reset and every input of the codec start at known values.
    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data_bits   = '0;
    logic                 in_valid        = 1'b0;
    logic                 in_ready;
    logic                 mode            = MODE_ENCODE;
    logic [DW_W-1:0]      data_word       = '0;
    logic [CW_W-1:0]      code_word       = '0;
    logic                 out_valid;
    logic                 out_ready       = 1'b0;
    logic [CW_W-1:0]      code_word_out;
    logic [DW_W-1:0]      data_out;
    logic [SYN_W-1:0]     error_position;
    logic [STATUS_W-1:0]  status;

    int                   fail_count;
    int                   pending;

    // The stimulus asks the sink for a long hold by raising hold_requests; the sink
    // process serves each request once and counts the stall itself.
    int                   hold_requests   = 0;
    int                   hold_served     = 0;
    int                   src_burst       = 0;
    logic [CFG_W-1:0]     width_now;

    hamming_sec_codec_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data_bits  (cfg_data_bits),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_mode           (mode),
        .i_data_word      (data_word),
        .i_code_word      (code_word),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_code_word_out  (code_word_out),
        .o_data_out       (data_out),
        .o_error_position (error_position),
        .o_status         (status)
    );

    // The watcher sees the same three channels as the codec, predicts every result
    // beat and compares it; it reports failures and outstanding beats back here.
    hamming_codec_checker codec_watch (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data_bits  (cfg_data_bits),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_mode           (mode),
        .i_data_word      (data_word),
        .i_code_word      (code_word),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_code_word_out  (code_word_out),
        .i_data_out       (data_out),
        .i_error_position (error_position),
        .i_status         (status),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Most gaps are short; about one in twenty is long.
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(1, 3);
    endfunction

    // Code word length for a width setting, with the out-of-range widths clamped.
    function automatic int code_length(input logic [CFG_W-1:0] width);
        int m;
        int r;
        m = int'(width);
        if (m < 1) begin
            m = 1;
        end
        if (m > MAX_DATA_BITS) begin
            m = MAX_DATA_BITS;
        end
        r = 0;
        while (r < 7 && (1 << r) < m + r + 1) begin
            r++;
        end
        return m + r;
    endfunction

    // Turns any pattern into a valid code word of length n. Every set bit of the
    // syndrome sits at a parity position inside the word, so flipping those parity
    // bits clears the syndrome without touching the data positions.
    function automatic logic [CW_W-1:0] clean_codeword(input logic [CW_W-1:0] raw, input int n);
        logic [CW_W-1:0] w;
        int              s;
        int              i;
        w = raw & ((CW_W'(1) << n) - CW_W'(1));
        s = 0;
        for (i = 1; i <= n; i++) begin
            if (w[i-1]) begin
                s = s ^ i;
            end
        end
        for (i = 0; i < SYN_W; i++) begin
            if (s[i]) begin
                w[(1 << i) - 1] = ~w[(1 << i) - 1];
            end
        end
        return w;
    endfunction

    // Sends one input beat, sometimes after a gap, and returns on the edge that
    // accepts it with valid still high, so that a following beat can go out at once.
    task automatic offer(input logic beat_mode, input logic [DW_W-1:0] beat_data,
                         input logic [CW_W-1:0] beat_code);
        int gap;
        gap = 0;
        if (src_burst > 0) begin
            src_burst--;
        end else if ($urandom_range(0, 59) == 0) begin
            src_burst = $urandom_range(20, 80);
        end else if ($urandom_range(0, 2) == 0) begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= beat_mode;
        data_word <= beat_data;
        code_word <= beat_code;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stops sending and waits until every predicted result beat has come back. The
    // count from the watcher is registered, so the task waits before its first check.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    // Writes the width register; only called while the codec holds nothing.
    task automatic set_width(input logic [CFG_W-1:0] width);
        cfg_valid     <= 1'b1;
        cfg_data_bits <= width;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_now = width;
    endtask

    // Sink side: ready drops for random gaps, with calm stretches where it stays
    // high, and for one long hold whenever the stimulus asks for it. Exactly one
    // assignment to out_ready happens on every edge.
    initial begin
        int sink_wait;
        int calm_left;
        sink_wait = 0;
        calm_left = 0;
        forever begin
            @(posedge clk);
            if (calm_left > 0) begin
                calm_left--;
            end else if ($urandom_range(0, 299) == 0) begin
                calm_left = $urandom_range(30, 100);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                out_ready <= 1'b0;
            end else if (hold_requests != hold_served) begin
                hold_served++;
                sink_wait = 150;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (calm_left == 0 && $urandom_range(0, 3) == 0) begin
                    sink_wait = pick_gap();
                end
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] widths [14];
        logic [CW_W-1:0]  word;
        logic [CW_W-1:0]  high_mask;
        int               n;
        int               pick;
        int               pos;

        // Register settings for the random phases: the smallest and largest widths,
        // both out-of-range forms, small odd sizes and one random value at the end.
        widths     = '{6'd1, 6'd0, 6'd63, 6'd33, 6'd2, 6'd3, 6'd5, 6'd11, 6'd26,
                       6'd31, 6'd32, 6'd57, 6'd4, 6'd0};
        widths[13] = CFG_W'($urandom_range(0, 63));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        width_now = RESET_DATA_BITS;

        // Directed beats at the width left by reset, with input bits beyond the
        // data width and beyond the code word length set.
        offer(MODE_ENCODE, 32'h0000_000F, '0);
        offer(MODE_ENCODE, 32'hFFFF_FFFF, 38'h3F_FFFF_FFFF);
        offer(MODE_DECODE, '0, 38'h00_0000_007F);
        offer(MODE_DECODE, 32'hFFFF_FFFF, 38'h3F_FFFF_FFFF);
        drain_results();

        // Directed beats at full width: extreme data words, a clean word, single
        // errors at the first, last and a parity position, and double errors, two of whose
        // syndromes point past the end of the code word.
        set_width(6'd32);
        offer(MODE_ENCODE, '0, '0);
        offer(MODE_ENCODE, 32'hFFFF_FFFF, '0);
        offer(MODE_ENCODE, 32'h8000_0001, 38'h15_5555_5555);
        offer(MODE_DECODE, '0, '0);
        offer(MODE_DECODE, '0, 38'h3F_FFFF_FFFF);
        word = clean_codeword(38'h3F_FFFF_FFFF, 38);
        offer(MODE_DECODE, '0, word);
        offer(MODE_DECODE, '0, word ^ (CW_W'(1) << 0));
        offer(MODE_DECODE, '0, word ^ (CW_W'(1) << 37));
        offer(MODE_DECODE, '0, word ^ (CW_W'(1) << 15));
        word = clean_codeword(CW_W'({$urandom(), $urandom()}), 38);
        offer(MODE_DECODE, '0, word ^ (CW_W'(1) << 31) ^ (CW_W'(1) << 6));
        offer(MODE_DECODE, '0, word ^ (CW_W'(1) << 31) ^ (CW_W'(1) << 30));
        offer(MODE_DECODE, '0, word ^ (CW_W'(1) << 37) ^ (CW_W'(1) << 1));
        drain_results();

        // Random phases, one per width setting. Decode beats are mostly valid code
        // words with zero, one or two flipped bits so that correction is exercised;
        // the rest are raw noise, which also reaches the bits above the length.
        for (int p = 0; p < 14; p++) begin
            set_width(widths[p]);
            n         = code_length(width_now);
            high_mask = ~((CW_W'(1) << n) - CW_W'(1));
            for (int j = 0; j < 90; j++) begin
                // Long receiver hold while beats keep coming: the pipe fills and
                // the codec has to stall its input.
                if (p == 6 && j == 20) begin
                    hold_requests++;
                end
                // Sender pause in the middle of a phase until everything is back.
                if (p == 9 && j == 45) begin
                    drain_results();
                end
                if ($urandom_range(0, 99) < 40) begin
                    offer(MODE_ENCODE, $urandom(), CW_W'({$urandom(), $urandom()}));
                end else begin
                    pick = $urandom_range(0, 99);
                    word = clean_codeword(CW_W'({$urandom(), $urandom()}), n);
                    if (pick < 20) begin
                        // Clean word, no error to find.
                    end else if (pick < 70) begin
                        pos  = $urandom_range(1, n);
                        word = word ^ (CW_W'(1) << (pos - 1));
                    end else if (pick < 85) begin
                        pos  = $urandom_range(1, n);
                        word = word ^ (CW_W'(1) << (pos - 1));
                        pos  = $urandom_range(1, n);
                        word = word ^ (CW_W'(1) << (pos - 1));
                    end else begin
                        word = CW_W'({$urandom(), $urandom()});
                    end
                    if (pick < 85 && $urandom_range(0, 3) == 0) begin
                        word = word | (CW_W'({$urandom(), $urandom()}) & high_mask);
                    end
                    offer(MODE_DECODE, $urandom(), word);
                end
            end
            drain_results();
        end

        // Everything is back; give the two pipeline stages time to show any
        // stray beat before the verdict.
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/hsc_pkg.sv
src/hamming_sec_codec_top.sv
tb/hamming_codec_checker.sv
tb/hamming_sec_codec_top_tb.sv
